// ===== rtl/nnfs_pkg.sv =====
package nnfs_pkg;

	// Width of fractional part of the 16.16 step accumulators
	localparam int FRAC_BITS = 16;
	localparam int ACC_W     = 32;
	localparam int STEP_W    = 25;
	localparam int REG_IDX_W = 3;
	localparam int REG_DAT_W = 25;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_EMIT = 1'b1
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_DST_WIDTH  = 3'd2,
		REG_DST_HEIGHT = 3'd3,
		REG_X_STEP     = 3'd4,
		REG_Y_STEP     = 3'd5
	} reg_idx_t;

	localparam logic [8:0]        RST_SRC_WIDTH  = 9'd320;
	localparam logic [7:0]        RST_SRC_HEIGHT = 8'd240;
	localparam logic [9:0]        RST_DST_WIDTH  = 10'd80;
	localparam logic [9:0]        RST_DST_HEIGHT = 10'd50;
	localparam logic [STEP_W-1:0] RST_X_STEP     = 25'd262144;
	localparam logic [STEP_W-1:0] RST_Y_STEP     = 25'd314572;

endpackage

// ===== rtl/nnfs_cmd_if.sv =====
interface nnfs_cmd_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] pixel_in;

	modport source (output valid, output command, output pixel_in, input ready);
	modport sink (input valid, input command, input pixel_in, output ready);
endinterface

// ===== rtl/nnfs_res_if.sv =====
interface nnfs_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_out;
	logic       frame_end;

	modport source (output valid, output pixel_out, output frame_end, input ready);
	modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

// ===== rtl/nnfs_cfg_if.sv =====
interface nnfs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [24:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/nnfs_store.sv =====
module nnfs_store #(
	parameter int DEPTH  = 76800,
	parameter int ADDR_W = 17
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);
	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;

	// Read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rd_q;
endmodule

// ===== rtl/nearest_neighbour_frame_scaler.sv =====
// Load: one transaction per cycle, written into the frame store at the accept edge; a load
// waits in the cycle right after an emit is accepted so it cannot overwrite the emit's entry.
// Emit: the result passes s1, s2, s3 and the output register; one emit in the pipe at a
// time, so a new emit waits until s1 to s3 are empty and its read follows earlier loads.
// Reset (arst_n low): counters, accumulators and load pointer clear, registers take
// their defaults; the frame store is not cleared and holds garbage until loaded.
module nearest_neighbour_frame_scaler #(
	parameter int MAX_SRC_WIDTH  = 320,
	parameter int MAX_SRC_HEIGHT = 240,
	parameter int MAX_DST_DIM    = 1023
) (
	input logic       clk,
	input logic       arst_n,
	nnfs_cmd_if.sink  cmd,
	nnfs_res_if.source result,
	nnfs_cfg_if.sink  cfg
);
	import nnfs_pkg::*;

	localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW_W   = $clog2(MAX_SRC_WIDTH + 1);
	localparam int SH_W   = $clog2(MAX_SRC_HEIGHT + 1);
	localparam int DD_W   = $clog2(MAX_DST_DIM + 1);
	localparam int COL_W  = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
	localparam int ROW_W  = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
	localparam int PROD_W = ROW_W + SW_W;
	localparam int FS_W   = SW_W + SH_W;

	// Configuration registers
	logic [8:0]        src_width_q;
	logic [7:0]        src_height_q;
	logic [9:0]        dst_width_q;
	logic [9:0]        dst_height_q;
	logic [STEP_W-1:0] x_step_q;
	logic [STEP_W-1:0] y_step_q;

	// Scan state
	logic [ADDR_W-1:0] load_ptr_q;
	logic [ACC_W-1:0]  x_acc_q;
	logic [ACC_W-1:0]  y_acc_q;
	logic [DD_W-1:0]   out_col_q;
	logic [DD_W-1:0]   out_row_q;

	// Emit pipeline
	logic              v_s1, v_s2, v_s3;
	logic              end_s1, end_s2, end_s3;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [ADDR_W-1:0] addr_s2;
	logic              out_valid_q;
	logic              out_end_q;
	logic [7:0]        out_pix_q;

	logic              emit_free;
	logic              cmd_fire;
	logic              load_fire;
	logic              emit_fire;
	logic              out_free;
	logic              s3_move;

	logic [SW_W-1:0]   sw, sw_m1;
	logic [SH_W-1:0]   sh, sh_m1;
	logic [DD_W-1:0]   dw_m1, dh_m1;
	logic [FS_W-1:0]   frame_size;
	logic [ADDR_W:0]   ptr_inc;
	logic [15:0]       x_int, y_int;
	logic [COL_W-1:0]  col_sel;
	logic [ROW_W-1:0]  row_sel;
	logic              last_col, last_row;
	logic [ACC_W:0]    x_sum, y_sum;
	logic [ACC_W-1:0]  x_next, y_next;
	logic [PROD_W-1:0] row_base;
	logic [ADDR_W-1:0] addr_n;
	logic [7:0]        rd_data;

	// Clamp dimensions: zero acts as 1, values above the build limit act as the limit
	always_comb begin
		if (src_width_q == '0) begin
			sw = SW_W'(1);
		end else if (32'(src_width_q) > 32'(MAX_SRC_WIDTH)) begin
			sw = SW_W'(MAX_SRC_WIDTH);
		end else begin
			sw = SW_W'(src_width_q);
		end
		if (src_height_q == '0) begin
			sh = SH_W'(1);
		end else if (32'(src_height_q) > 32'(MAX_SRC_HEIGHT)) begin
			sh = SH_W'(MAX_SRC_HEIGHT);
		end else begin
			sh = SH_W'(src_height_q);
		end
		if (dst_width_q == '0) begin
			dw_m1 = '0;
		end else if (32'(dst_width_q) > 32'(MAX_DST_DIM)) begin
			dw_m1 = DD_W'(MAX_DST_DIM - 1);
		end else begin
			dw_m1 = DD_W'(dst_width_q - 10'd1);
		end
		if (dst_height_q == '0) begin
			dh_m1 = '0;
		end else if (32'(dst_height_q) > 32'(MAX_DST_DIM)) begin
			dh_m1 = DD_W'(MAX_DST_DIM - 1);
		end else begin
			dh_m1 = DD_W'(dst_height_q - 10'd1);
		end
	end

	assign sw_m1 = sw - SW_W'(1);
	assign sh_m1 = sh - SH_W'(1);

	// Load pointer wraps after the last pixel of the clamped source frame
	assign frame_size = FS_W'(sw) * FS_W'(sh);
	assign ptr_inc    = (ADDR_W + 1)'(load_ptr_q) + (ADDR_W + 1)'(1);

	// Source position: integer part of the accumulators, held at the frame edge
	assign x_int   = x_acc_q[ACC_W-1:FRAC_BITS];
	assign y_int   = y_acc_q[ACC_W-1:FRAC_BITS];
	assign col_sel = (32'(x_int) > 32'(sw_m1)) ? COL_W'(sw_m1) : COL_W'(x_int);
	assign row_sel = (32'(y_int) > 32'(sh_m1)) ? ROW_W'(sh_m1) : ROW_W'(y_int);

	// A counter at or past a shrunk limit counts as the last one
	assign last_col = 32'(out_col_q) >= 32'(dw_m1);
	assign last_row = 32'(out_row_q) >= 32'(dh_m1);

	// Saturating accumulator advance
	assign x_sum  = (ACC_W + 1)'(x_acc_q) + (ACC_W + 1)'(x_step_q);
	assign y_sum  = (ACC_W + 1)'(y_acc_q) + (ACC_W + 1)'(y_step_q);
	assign x_next = x_sum[ACC_W] ? '1 : x_sum[ACC_W-1:0];
	assign y_next = y_sum[ACC_W] ? '1 : y_sum[ACC_W-1:0];

	// Raster address of the selected source pixel
	assign row_base = PROD_W'(row_s1) * PROD_W'(sw);
	assign addr_n   = ADDR_W'(row_base + PROD_W'(col_s1));

	// Loads go straight to the store, except while an emit sits in s1: a load taken then
	// would be written before that emit's read and could overwrite its entry. An emit
	// waits until the pipe is empty, so its read follows every earlier load.
	assign emit_free = !(v_s1 || v_s2 || v_s3);
	assign cmd.ready = (cmd_t'(cmd.command) == CMD_LOAD) ? !v_s1 : emit_free;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign load_fire = cmd_fire && (cmd_t'(cmd.command) == CMD_LOAD);
	assign emit_fire = cmd_fire && (cmd_t'(cmd.command) == CMD_EMIT);
	assign cfg.ready = 1'b1;

	// Output register parts the result side from the pipe
	assign out_free = !out_valid_q || result.ready;
	assign s3_move  = v_s3 && out_free;

	nnfs_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (load_fire),
		.waddr (load_ptr_q),
		.wdata (cmd.pixel_in),
		.re    (v_s2),
		.raddr (addr_s2),
		.rdata (rd_data)
	);

	// Configuration transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= RST_SRC_WIDTH;
			src_height_q <= RST_SRC_HEIGHT;
			dst_width_q  <= RST_DST_WIDTH;
			dst_height_q <= RST_DST_HEIGHT;
			x_step_q     <= RST_X_STEP;
			y_step_q     <= RST_Y_STEP;
		end else if (cfg.valid && cfg.ready) begin
			case (reg_idx_t'(cfg.index))
				REG_SRC_WIDTH:  src_width_q  <= cfg.data[8:0];
				REG_SRC_HEIGHT: src_height_q <= cfg.data[7:0];
				REG_DST_WIDTH:  dst_width_q  <= cfg.data[9:0];
				REG_DST_HEIGHT: dst_height_q <= cfg.data[9:0];
				REG_X_STEP:     x_step_q     <= cfg.data[STEP_W-1:0];
				REG_Y_STEP:     y_step_q     <= cfg.data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Load pointer and destination scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr_q <= '0;
			x_acc_q    <= '0;
			y_acc_q    <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
		end else begin
			if (load_fire) begin
				if (32'(ptr_inc) >= 32'(frame_size)) begin
					load_ptr_q <= '0;
				end else begin
					load_ptr_q <= ADDR_W'(ptr_inc);
				end
			end
			if (emit_fire) begin
				if (!last_col) begin
					out_col_q <= out_col_q + DD_W'(1);
					x_acc_q   <= x_next;
				end else begin
					out_col_q <= '0;
					x_acc_q   <= '0;
					if (!last_row) begin
						out_row_q <= out_row_q + DD_W'(1);
						y_acc_q   <= y_next;
					end else begin
						out_row_q <= '0;
						y_acc_q   <= '0;
					end
				end
			end
		end
	end

	// Emit pipeline control: s1 position, s2 address, s3 store data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= emit_fire;
			v_s2 <= v_s1;
			if (v_s2) begin
				v_s3 <= 1'b1;
			end else if (s3_move) begin
				v_s3 <= 1'b0;
			end
			if (s3_move) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pipeline payload; s3 data is held inside the store's read register
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			col_s1 <= col_sel;
			row_s1 <= row_sel;
			end_s1 <= last_col && last_row;
		end
		if (v_s1) begin
			addr_s2 <= addr_n;
			end_s2  <= end_s1;
		end
		if (v_s2) begin
			end_s3 <= end_s2;
		end
		if (s3_move) begin
			out_pix_q <= rd_data;
			out_end_q <= end_s3;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.pixel_out = out_pix_q;
	assign result.frame_end = out_end_q;

`ifndef NO_ASSERTIONS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1, v_s2, v_s3}))
		else $error("more than one emit in the pipe");

	a_no_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2 || v_s3) |-> !emit_fire)
		else $error("emit accepted while pipe busy");

	a_no_load_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !load_fire)
		else $error("load accepted ahead of a pending store read");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && out_valid_q && !result.ready) |=> v_s3)
		else $error("store data dropped while output blocked");
`endif

endmodule
